[sv/linear_probe_hash_table_top_assert.svh]
// Assertion macros used by the checker file of the hash table.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define LPHT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/lpht_pkg.sv]
package lpht_pkg;

	localparam int SLOTS  = 32;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int KEY_W  = 32;
	localparam int VAL_W  = 32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK
	} lpht_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the incoming item and its home slot
		logic rd;         // read the entry at the current slot
		logic step;       // move to the next slot
		logic write;      // store the item at the current slot
		logic res_load;   // capture a result
		logic res_ok;     // success flag of that result
	} lpht_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_lookup;
		logic occupied;
		logic key_match;
		logic last_probe;
	} lpht_stat_t;

endpackage

[sv/lpht_datapath.sv]
module lpht_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lpht_pkg::lpht_cmd_t      cmd,
	output lpht_pkg::lpht_stat_t     stat,
	input  logic                     operation,
	input  logic signed [31:0]       key,
	input  logic signed [31:0]       item_value,
	output logic                     success,
	output logic signed [31:0]       found_value
);

	logic [lpht_pkg::KEY_W-1:0]                  entry_key_mem [lpht_pkg::SLOTS];
	logic [lpht_pkg::VAL_W-1:0]                  entry_val_mem [lpht_pkg::SLOTS];
	logic [lpht_pkg::SLOTS-1:0]                  occ_q;
	logic                                        op_q;
	logic [lpht_pkg::KEY_W-1:0]                  key_q;
	logic [lpht_pkg::VAL_W-1:0]                  val_q;
	logic [lpht_pkg::SLOT_W-1:0]                 slot_q;
	logic [lpht_pkg::SLOT_W-1:0]                 probe_q;
	logic [lpht_pkg::KEY_W-1:0]                  rd_key_q;
	logic [lpht_pkg::VAL_W-1:0]                  rd_val_q;
	logic                                        success_q;
	logic [lpht_pkg::VAL_W-1:0]                  found_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			key_q <= key;
			val_q <= item_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			probe_q <= '0;
		end else if (cmd.load) begin
			slot_q  <= key[lpht_pkg::SLOT_W-1:0];
			probe_q <= '0;
		end else if (cmd.step) begin
			slot_q  <= slot_q + 1'b1;
			probe_q <= probe_q + 1'b1;
		end
	end

	// Key and value store: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			entry_key_mem[slot_q] <= key_q;
			entry_val_mem[slot_q] <= val_q;
		end
		if (cmd.rd) begin
			rd_key_q <= entry_key_mem[slot_q];
			rd_val_q <= entry_val_mem[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.write) begin
			occ_q[slot_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			success_q <= cmd.res_ok;
			found_q   <= (cmd.res_ok && op_q == lpht_pkg::OP_LOOKUP) ? rd_val_q : '0;
		end
	end

	always_comb begin
		stat.is_lookup  = (op_q == lpht_pkg::OP_LOOKUP);
		stat.occupied   = occ_q[slot_q];
		stat.key_match  = (rd_key_q == key_q);
		stat.last_probe = (probe_q == lpht_pkg::SLOT_W'(lpht_pkg::SLOTS - 1));
	end

	assign success     = success_q;
	assign found_value = found_q;

endmodule

[sv/lpht_ctrl.sv]
module lpht_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  lpht_pkg::lpht_stat_t  stat,
	output lpht_pkg::lpht_cmd_t   cmd
);

	lpht_pkg::lpht_state_t state_q, state_d;
	logic                  out_valid_q;
	logic                  res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpht_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_free = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			lpht_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = lpht_pkg::ST_READ;
				end
			end
			lpht_pkg::ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = lpht_pkg::ST_CHECK;
			end
			lpht_pkg::ST_CHECK: begin
				priority if (!stat.occupied) begin
					// A free slot ends both an insert and a lookup.
					if (res_free) begin
						cmd.res_load = 1'b1;
						cmd.res_ok   = !stat.is_lookup;
						cmd.write    = !stat.is_lookup;
						state_d      = lpht_pkg::ST_IDLE;
					end
				end else if (stat.is_lookup && stat.key_match) begin
					if (res_free) begin
						cmd.res_load = 1'b1;
						cmd.res_ok   = 1'b1;
						state_d      = lpht_pkg::ST_IDLE;
					end
				end else if (stat.last_probe) begin
					if (res_free) begin
						cmd.res_load = 1'b1;
						state_d      = lpht_pkg::ST_IDLE;
					end
				end else begin
					cmd.step = 1'b1;
					state_d  = lpht_pkg::ST_READ;
				end
			end
			default: begin
				state_d = lpht_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[sv/linear_probe_hash_table_top.sv]
// From input beat to result, an item settled at its home slot takes one read and one check,
// plus a further read and check for every further slot probed, up to all 32 slots.
// Throughput: one item at a time, set by the single read port of the key/value store
// and the read-then-check probe loop.
// Reset (arst_n, asynchronous, active low) clears all occupied marks and the controller.
module linear_probe_hash_table_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic signed [31:0] key,
	input  logic signed [31:0] item_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               success,
	output logic signed [31:0] found_value
);

	// The controller walks the probe sequence: it accepts a beat when idle, then
	// alternates between reading the entry at the current slot and checking it.
	// A check ends the walk at a free slot (insert stores there, lookup misses),
	// at a matching key on a lookup, or after the last of the table's slots.
	// The result sits in its own register, so the walk only pauses when a
	// previous result has not yet been taken.
	lpht_pkg::lpht_cmd_t  cmd;
	lpht_pkg::lpht_stat_t stat;

	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the key/value store, the occupied marks, the slot and
	// probe counters, and the result register.
	lpht_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.operation   (operation),
		.key         (key),
		.item_value  (item_value),
		.success     (success),
		.found_value (found_value)
	);

endmodule

[sv/lpht_checker.sv]
`include "linear_probe_hash_table_top_assert.svh"

module lpht_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               success,
	input logic signed [31:0] found_value
);

	`LPHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
	`LPHT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(success) && $stable(found_value), "result changed while stalled")
	`LPHT_ASSERT_SAME(a_miss_zero, out_valid && !success, found_value == 32'sd0, "failed result carries a value")
	`LPHT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "second beat taken during a probe walk")

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.success     (success),
	.found_value (found_value)
);
